/* rtl/gcds_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package gcds_pkg;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 34;
  localparam logic [CfgIdxW-1:0] RegGridSize = 2'd0;
  localparam logic [CfgIdxW-1:0] RegCellPitch = 2'd1;
  localparam logic [CfgIdxW-1:0] RegCutoffSq = 2'd2;
  localparam int unsigned SumW = 48;
  localparam int unsigned TotalW = 63;
  localparam int unsigned GridW = 7;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;      // capture particle and clear the sum
    logic step;      // evaluate one cell and accumulate
    logic finish;    // fold the sum into the total
  } gcds_cmd_t;

  // Status back to the controller.
  typedef struct packed {
    logic sqrt_busy;
  } gcds_sts_t;
endpackage
`default_nettype wire

/* rtl/gcds_isqrt.sv */
`timescale 1ns / 1ps
`default_nettype none
// Iterative integer square root, one result bit per cycle.
module gcds_isqrt #(
  parameter int unsigned InW = 62
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [InW-1:0]    val_i,
  output logic                   busy_o,
  output logic                   done_o,
  output logic [InW/2-1:0]       root_o
);
  localparam int unsigned OutW = InW / 2;
  localparam int unsigned CntW = $clog2(OutW + 1);

  logic [InW-1:0]  rem_q, rem_d;
  logic [InW-1:0]  src_q, src_d;
  logic [OutW-1:0] root_q, root_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d, done_q, done_d;
  logic [InW+1:0]  trial;
  logic [InW+1:0]  remsh;

  always_comb begin
    remsh  = {rem_q, src_q[InW-1 -: 2]};
    trial  = {{(InW - OutW){1'b0}}, root_q, 2'b01};
    rem_d  = rem_q;
    src_d  = src_q;
    root_d = root_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      src_d  = val_i;
      root_d = '0;
      cnt_d  = CntW'(OutW);
      busy_d = 1'b1;
    end else if (busy_q) begin
      src_d = {src_q[InW-3:0], 2'b00};
      if (remsh >= trial) begin
        rem_d  = InW'(remsh - trial);
        root_d = {root_q[OutW-2:0], 1'b1};
      end else begin
        rem_d  = InW'(remsh);
        root_d = {root_q[OutW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    src_q  <= src_d;
    root_q <= root_d;
  end

  assign busy_o = busy_q;
  assign done_o = done_q;
  assign root_o = root_q;
endmodule
`default_nettype wire

/* rtl/gcds_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// Cell walker, distance arithmetic, square root and accumulators.
module gcds_datapath #(
  parameter int unsigned MaxGrid = 64,
  parameter int unsigned FracW   = 16
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire gcds_pkg::gcds_cmd_t     cmd_i,
  output gcds_pkg::gcds_sts_t          sts_o,
  output logic                         cells_done_o,
  input  wire logic [FracW-1:0]        pos_x_i,
  input  wire logic [FracW-1:0]        pos_y_i,
  input  wire logic [FracW-1:0]        pos_z_i,
  input  wire logic                    last_i,
  input  wire logic [gcds_pkg::GridW-1:0] grid_i,
  input  wire logic [FracW-1:0]        pitch_i,
  input  wire logic [2*FracW+1:0]      cut_i,
  output logic [gcds_pkg::SumW-1:0]    sum_o,
  output logic [gcds_pkg::TotalW-1:0]  total_o,
  output logic                         last_o
);
  localparam int unsigned IdxW  = $clog2(MaxGrid);
  localparam int unsigned NW    = $clog2(MaxGrid + 1);
  localparam int unsigned CW    = FracW + IdxW + 2;  // center width
  localparam int unsigned SqW   = 63;
  localparam logic [SqW-1:0] SqCap = SqW'(64'd1 << 62);
  localparam int unsigned SW    = gcds_pkg::SumW;
  localparam int unsigned TW    = gcds_pkg::TotalW;

  logic [FracW-1:0] px_q, py_q, pz_q;
  logic             last_q;
  logic [IdxW-1:0]  i_q, j_q, k_q;
  logic [NW-1:0]    n_q;
  logic             walk_q;
  logic [SW-1:0]    sum_q;
  logic [TW-1:0]    total_q;
  logic [SqW-1:0]   sx_q, sy_q, sz_q;
  logic             sq_v_q;
  logic [SqW+1:0]   d2_q;
  logic             d2_v_q;
  logic [2*FracW+3:0] lim_q;
  logic             in_rng;
  logic             sq_start;
  logic             sq_busy, sq_done;
  logic [30:0]      root;
  logic [NW-1:0]    n_eff;

  function automatic logic [SqW-1:0] axis_sq(input logic [FracW-1:0] p,
                                             input logic [IdxW-1:0] idx,
                                             input logic [FracW-1:0] pitch);
    logic [CW-1:0] c;
    logic [CW-1:0] p2;
    logic [CW-1:0] d;
    c  = CW'({idx, 1'b1}) * CW'(pitch);
    p2 = CW'({p, 1'b0});
    d  = (p2 >= c) ? p2 - c : c - p2;
    if (CW > 31 && (d >> 31) != '0) return SqCap;
    return SqW'(d) * SqW'(d);
  endfunction

  assign n_eff = (32'(grid_i) > 32'(MaxGrid)) ? NW'(MaxGrid) : NW'(grid_i);

  // Stage 1: axis squares; stage 2: sum and compare; then serial root.
  always_ff @(posedge clk_i) begin
    sx_q <= axis_sq(px_q, i_q, pitch_i);
    sy_q <= axis_sq(py_q, j_q, pitch_i);
    sz_q <= axis_sq(pz_q, k_q, pitch_i);
    d2_q <= (SqW+2)'(sx_q) + (SqW+2)'(sy_q) + (SqW+2)'(sz_q);
    if (cmd_i.load) begin
      px_q <= pos_x_i;
      py_q <= pos_y_i;
      pz_q <= pos_z_i;
      last_q <= last_i;
      lim_q <= {cut_i, 2'b00};
    end
  end

  assign in_rng   = d2_v_q && (d2_q < (SqW+2)'(lim_q));
  assign sq_start = in_rng;

  gcds_isqrt #(.InW(62)) u_isqrt (
    .clk_i, .rst_ni,
    .start_i (sq_start),
    .val_i   (62'(d2_q >> 2)),
    .busy_o  (sq_busy),
    .done_o  (sq_done),
    .root_o  (root)
  );

  logic [SW:0]   sum_add;
  logic [TW:0]   tot_add;
  logic          adv;
  assign adv = cmd_i.step && walk_q;
  assign sum_add = (SW+1)'(sum_q) + (SW+1)'(root);
  assign tot_add = (TW+1)'(total_q) + (TW+1)'(sum_q);

  // The front end is empty whenever a load arrives, so the valid bits just follow adv.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      walk_q <= 1'b0; sq_v_q <= 1'b0; d2_v_q <= 1'b0;
      i_q <= '0; j_q <= '0; k_q <= '0; n_q <= '0;
      sum_q <= '0; total_q <= '0;
    end else begin
      sq_v_q <= adv;
      d2_v_q <= sq_v_q;
      if (cmd_i.load) begin
        n_q <= n_eff;
        i_q <= '0; j_q <= '0; k_q <= '0;
        walk_q <= (n_eff != '0);
        sum_q <= '0;
      end else if (adv) begin
        if (NW'(k_q) + 1'b1 < n_q) k_q <= k_q + 1'b1;
        else begin
          k_q <= '0;
          if (NW'(j_q) + 1'b1 < n_q) j_q <= j_q + 1'b1;
          else begin
            j_q <= '0;
            if (NW'(i_q) + 1'b1 < n_q) i_q <= i_q + 1'b1;
            else walk_q <= 1'b0;
          end
        end
      end
      if (sq_done) sum_q <= sum_add[SW] ? '1 : sum_add[SW-1:0];
      if (cmd_i.finish) begin
        total_q <= (last_q) ? '0 : (tot_add[TW] ? '1 : tot_add[TW-1:0]);
      end
    end
  end

  // Result registers captured at finish.
  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      sum_o   <= sum_q;
      total_o <= tot_add[TW] ? '1 : tot_add[TW-1:0];
      last_o  <= last_q;
    end
  end

  // Step is issued only when the root unit is idle, so one cell is in flight.
  assign sts_o.sqrt_busy = sq_busy || sq_start || sq_v_q || d2_v_q || sq_done;
  assign cells_done_o    = !walk_q;
endmodule
`default_nettype wire

/* rtl/gcds_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// Sequencer: load, walk the cells, finish, present the result.
module gcds_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  input  wire gcds_pkg::gcds_sts_t  sts_i,
  input  wire logic                 cells_done_i,
  output gcds_pkg::gcds_cmd_t       cmd_o
);
  typedef enum logic [1:0] {StIdle, StWalk, StDrain, StFinish} state_e;
  state_e state_q;
  logic   out_v_q;

  // A new item may start while the previous result still waits in the output registers.
  logic accept;
  assign accept = in_valid_i && (state_q == StIdle);

  always_comb begin
    cmd_o.load   = accept;
    cmd_o.step   = (state_q == StWalk) && !sts_i.sqrt_busy;
    cmd_o.finish = (state_q == StFinish);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      out_v_q <= 1'b0;
    end else begin
      if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      unique case (state_q)
        StIdle:   if (accept) state_q <= StWalk;
        StWalk:   if (cells_done_i) state_q <= StDrain;
        // Finish overwrites the output registers, so it waits for the old result to leave.
        StDrain:  if (!sts_i.sqrt_busy && !out_v_q) state_q <= StFinish;
        StFinish: begin
          state_q <= StIdle;
          out_v_q <= 1'b1;
        end
        default:  state_q <= StIdle;
      endcase
    end
  end

  assign in_stall_o  = (state_q != StIdle);
  assign out_valid_o = out_v_q;
endmodule
`default_nettype wire

/* rtl/grid_cutoff_distance_sum_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Each cell inside the cutoff passes the front end (axis squares, then sum and compare)
// and then the 31-bit serial square root; a cell outside it skips the root. An item
// walks grid_size^3 cells (grid size clamped to MAX_GRID), plus load and finish.
// Throughput: one item at a time; the serial root unit sets the rate. The next item
// may be taken while the previous result waits; it then finishes only once that leaves.
// Reset clears the running total, the controller and the registers to defaults.
module grid_cutoff_distance_sum_unit #(
  parameter int unsigned MAX_GRID        = 64,
  parameter int unsigned COORD_FRAC_BITS = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [COORD_FRAC_BITS-1:0]        pos_x_i,
  input  wire logic [COORD_FRAC_BITS-1:0]        pos_y_i,
  input  wire logic [COORD_FRAC_BITS-1:0]        pos_z_i,
  input  wire logic                              last_particle_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [gcds_pkg::SumW-1:0]              particle_sum_o,
  output logic [gcds_pkg::TotalW-1:0]            running_total_o,
  output logic                                   is_last_o,
  input  wire logic                              cfg_we_i,
  input  wire logic [gcds_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  wire logic [2*COORD_FRAC_BITS+1:0]      cfg_data_i
);
  localparam int unsigned CutW = 2 * COORD_FRAC_BITS + 2;
  // Reset pitch is one sixteenth and the reset cutoff 0.2 squared, for any coordinate width.
  localparam logic [63:0] CutRst34 = 64'd171798692;
  localparam logic [CutW-1:0] CutRst = (CutW >= 34) ? CutW'(CutRst34 << (CutW - 34))
                                                    : CutW'(CutRst34 >> (34 - CutW));
  localparam logic [COORD_FRAC_BITS-1:0] PitchRst = COORD_FRAC_BITS'(1 << (COORD_FRAC_BITS - 4));

  logic [gcds_pkg::GridW-1:0] grid_q;
  logic [COORD_FRAC_BITS-1:0] pitch_q;
  logic [CutW-1:0]            cut_q;

  // Configuration registers; writes outside the list are dropped.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q  <= gcds_pkg::GridW'(16);
      pitch_q <= PitchRst;
      cut_q   <= CutRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        gcds_pkg::RegGridSize:  grid_q  <= cfg_data_i[gcds_pkg::GridW-1:0];
        gcds_pkg::RegCellPitch: pitch_q <= cfg_data_i[COORD_FRAC_BITS-1:0];
        gcds_pkg::RegCutoffSq:  cut_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  gcds_pkg::gcds_cmd_t cmd;
  gcds_pkg::gcds_sts_t sts;
  logic                cells_done;

  gcds_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i,
    .sts_i (sts), .cells_done_i (cells_done), .cmd_o (cmd)
  );

  gcds_datapath #(.MaxGrid(MAX_GRID), .FracW(COORD_FRAC_BITS)) u_dp (
    .clk_i, .rst_ni,
    .cmd_i (cmd), .sts_o (sts), .cells_done_o (cells_done),
    .pos_x_i, .pos_y_i, .pos_z_i, .last_i (last_particle_i),
    .grid_i (grid_q), .pitch_i (pitch_q), .cut_i (cut_q),
    .sum_o (particle_sum_o), .total_o (running_total_o), .last_o (is_last_o)
  );
endmodule
`default_nettype wire

/* rtl/gcds_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module gcds_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_stall_o,
  input wire logic out_valid_o,
  input wire logic out_stall_i,
  input wire logic is_last_o
);
  // Only one item is taken at a time.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o) else $error("second item taken at once");
  // A result is never raised in the cycle right after an accept.
  a_min_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> !$rose(out_valid_o)) else $error("result too early");
  // A stalled result holds its flag.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(is_last_o)))
    else $error("stalled result changed");
endmodule
bind grid_cutoff_distance_sum_unit gcds_checker u_gcds_checker (
  .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .out_valid_o, .out_stall_i, .is_last_o
);
`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 1ps
module tb_top;

  // Register index that the block has no register behind; writes to it must be dropped.
  localparam logic [gcds_pkg::CfgIdxW-1:0] RegUnused = 2'd3;
  localparam int unsigned IdleLimit = 5000000;
  localparam logic [33:0] CutMax = 34'h3_FFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [15:0] pos_x_i = '0, pos_y_i = '0, pos_z_i = '0;
  logic last_particle_i = 1'b0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic [gcds_pkg::SumW-1:0] particle_sum_o;
  logic [gcds_pkg::TotalW-1:0] running_total_o;
  logic is_last_o;
  logic cfg_we_i = 1'b0;
  logic [gcds_pkg::CfgIdxW-1:0] cfg_idx_i = '0;
  logic [gcds_pkg::CfgDataW-1:0] cfg_data_i = '0;

  grid_cutoff_distance_sum_unit i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .pos_x_i, .pos_y_i, .pos_z_i,
    .last_particle_i, .out_valid_o, .out_stall_i, .particle_sum_o, .running_total_o,
    .is_last_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Our own copy of the registers and of the running total, updated as items are accepted.
  logic [6:0] grid_cells;
  logic [15:0] pitch;
  logic [33:0] cutoff_sq;
  logic [62:0] total_acc;

  typedef struct {
    logic [gcds_pkg::SumW-1:0] sum;
    logic [gcds_pkg::TotalW-1:0] total;
    logic last;
  } distance_result_t;
  distance_result_t pending_results[$];

  int errors = 0;
  int items_sent = 0;
  int results_seen = 0;
  int cfg_writes = 0;
  bit quiet = 1'b0;      // When set, neither side inserts random bubbles.
  bit hold_req = 1'b0;   // Asks the receiver for one long stall.
  int idle_cycles = 0;

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  // Integer square root by the classic bit-pair method; the result is truncated.
  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] rem, root, probe;
    rem = v;
    root = '0;
    probe = 64'h1 << 62;
    while (probe > rem) probe = probe >> 2;
    while (probe != 0) begin
      if (rem >= root + probe) begin
        rem = rem - (root + probe);
        root = (root >> 1) + probe;
      end else begin
        root = root >> 1;
      end
      probe = probe >> 2;
    end
    return root;
  endfunction

  // Squared offset from a coordinate to every cell center along one axis. Centers sit at
  // (2i+1)*pitch in half units, so the half cell stays exact; far offsets are capped.
  function automatic void axis_offsets(input logic [15:0] coord, input int n,
                                       output logic [63:0] sq[64]);
    logic [63:0] p2, ctr, d;
    p2 = {47'd0, coord, 1'b0};
    for (int i = 0; i < 64; i++) begin
      sq[i] = '0;
      if (i < n) begin
        ctr = (2 * i + 1) * {48'd0, pitch};
        d = (p2 >= ctr) ? p2 - ctr : ctr - p2;
        sq[i] = (d >= (64'h1 << 31)) ? (64'h1 << 62) : d * d;
      end
    end
  endfunction

  function automatic logic [gcds_pkg::SumW-1:0] cutoff_distance_sum(input logic [15:0] x,
                                                                    input logic [15:0] y,
                                                                    input logic [15:0] z);
    logic [63:0] sx[64], sy[64], sz[64];
    logic [63:0] reach, d2, acc;
    int n;
    n = (grid_cells > 64) ? 64 : int'(grid_cells);
    axis_offsets(x, n, sx);
    axis_offsets(y, n, sy);
    axis_offsets(z, n, sz);
    reach = {28'd0, cutoff_sq, 2'b00};
    acc = '0;
    for (int i = 0; i < n; i++)
      for (int j = 0; j < n; j++)
        for (int k = 0; k < n; k++) begin
          d2 = sx[i] + sy[j] + sz[k];
          if (d2 < reach) begin
            acc = acc + int_sqrt(d2 >> 2);
            if (acc > 64'hFFFF_FFFF_FFFF) acc = 64'hFFFF_FFFF_FFFF;
          end
        end
    return acc[gcds_pkg::SumW-1:0];
  endfunction

  task automatic write_reg(input logic [gcds_pkg::CfgIdxW-1:0] idx,
                           input logic [gcds_pkg::CfgDataW-1:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      gcds_pkg::RegGridSize: grid_cells = data[6:0];
      gcds_pkg::RegCellPitch: pitch = data[15:0];
      gcds_pkg::RegCutoffSq: cutoff_sq = data[33:0];
      default: ;
    endcase
    cfg_writes++;
  endtask

  // Stops offering items and waits until every expected result has come back.
  task automatic drain();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (4) @(negedge clk_i);
  endtask

  // Offers one particle and, once it is taken, records what the block must answer.
  // A typed-in sum, where given, overrides the predicted one.
  task automatic send_particle(input logic [15:0] x, input logic [15:0] y,
                               input logic [15:0] z, input logic last,
                               input bit fixed, input logic [gcds_pkg::SumW-1:0] fixed_sum);
    distance_result_t r;
    logic [63:0] t;
    @(negedge clk_i);
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    pos_x_i <= x;
    pos_y_i <= y;
    pos_z_i <= z;
    last_particle_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    r.sum = fixed ? fixed_sum : cutoff_distance_sum(x, y, z);
    t = {1'b0, total_acc} + {16'd0, r.sum};
    if (t > 64'h7FFF_FFFF_FFFF_FFFF) t = 64'h7FFF_FFFF_FFFF_FFFF;
    r.total = t[62:0];
    r.last = last;
    total_acc = last ? '0 : t[62:0];
    pending_results.push_back(r);
    items_sent++;
  endtask

  // Receiver: random short stalls, one long hold on request, none when quiet.
  initial begin
    forever begin
      @(negedge clk_i);
      if (hold_req) begin
        out_stall_i <= 1'b1;
        repeat (400) @(negedge clk_i);
        out_stall_i <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk_i);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // Compare each accepted result against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      distance_result_t r;
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("MISMATCH unexpected result at %0t", $realtime);
        errors++;
      end else begin
        r = pending_results.pop_front();
        if (particle_sum_o !== r.sum) report_mismatch("particle_sum", particle_sum_o, r.sum);
        if (running_total_o !== r.total)
          report_mismatch("running_total", running_total_o, r.total);
        if (is_last_o !== r.last) report_mismatch("is_last", is_last_o, r.last);
      end
    end
  end

  // Watchdog on cycles in which neither channel moves anything.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("tb_top failed");
      $finish;
    end
  end

  // Directed rows: either a register write (taken only once the block is drained) or
  // a particle, with a typed-in sum where it is obvious.
  typedef struct {
    bit is_cfg;
    logic [gcds_pkg::CfgIdxW-1:0] idx;
    logic [gcds_pkg::CfgDataW-1:0] data;
    logic [15:0] x, y, z;
    logic last;
    bit fixed;
    logic [gcds_pkg::SumW-1:0] sum;
  } stim_row_t;

  function automatic stim_row_t cfg_row(input logic [gcds_pkg::CfgIdxW-1:0] idx,
                                        input logic [gcds_pkg::CfgDataW-1:0] data);
    stim_row_t s;
    s = '{1'b1, idx, data, '0, '0, '0, 1'b0, 1'b0, '0};
    return s;
  endfunction

  function automatic stim_row_t item_row(input logic [15:0] x, input logic [15:0] y,
                                         input logic [15:0] z, input logic last,
                                         input bit fixed,
                                         input logic [gcds_pkg::SumW-1:0] sum);
    stim_row_t s;
    s = '{1'b0, gcds_pkg::RegGridSize, '0, x, y, z, last, fixed, sum};
    return s;
  endfunction

  stim_row_t directed[$];

  initial begin
    logic [gcds_pkg::CfgDataW-1:0] v;
    grid_cells = 7'd16;
    pitch = 16'd4096;
    cutoff_sq = 34'd171798692;
    total_acc = '0;

    // Default settings after reset, at the corners and the middle of the box.
    directed.push_back(item_row(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, '0));
    directed.push_back(item_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0, '0));
    directed.push_back(item_row(16'h8000, 16'h8000, 16'h8000, 1'b0, 1'b0, '0));
    // A write to the unused index must leave every register alone.
    directed.push_back(cfg_row(RegUnused, '1));
    directed.push_back(item_row(16'h4000, 16'hC000, 16'h2000, 1'b1, 1'b0, '0));
    // An empty grid yields nothing.
    directed.push_back(cfg_row(gcds_pkg::RegGridSize, '0));
    directed.push_back(item_row(16'h1234, 16'hFEDC, 16'h0F0F, 1'b1, 1'b1, '0));
    // One cell of half width, centered at a quarter, widest cutoff: a particle on that
    // center is at zero.
    directed.push_back(cfg_row(gcds_pkg::RegGridSize, 34'd1));
    directed.push_back(cfg_row(gcds_pkg::RegCellPitch, 34'd32768));
    directed.push_back(cfg_row(gcds_pkg::RegCutoffSq, CutMax));
    directed.push_back(item_row(16'h4000, 16'h4000, 16'h4000, 1'b0, 1'b1, '0));
    directed.push_back(item_row(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0, '0));
    directed.push_back(item_row(16'hFFFF, 16'h0000, 16'hFFFF, 1'b1, 1'b0, '0));
    // Widest pitch, so far cells land outside the box.
    directed.push_back(cfg_row(gcds_pkg::RegCellPitch, 34'd65535));
    directed.push_back(cfg_row(gcds_pkg::RegGridSize, 34'd2));
    directed.push_back(item_row(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, '0));
    directed.push_back(item_row(16'h0000, 16'h0000, 16'h0000, 1'b1, 1'b0, '0));
    // Narrowest pitch.
    directed.push_back(cfg_row(gcds_pkg::RegCellPitch, 34'd1));
    directed.push_back(cfg_row(gcds_pkg::RegGridSize, 34'd4));
    directed.push_back(item_row(16'hAAAA, 16'h5555, 16'hFFFF, 1'b0, 1'b0, '0));
    // Zero cutoff with an oversized grid, clamped to the largest one: nothing is in range.
    directed.push_back(cfg_row(gcds_pkg::RegCutoffSq, '0));
    directed.push_back(cfg_row(gcds_pkg::RegGridSize, 34'd127));
    directed.push_back(item_row(16'h5555, 16'hAAAA, 16'h0001, 1'b1, 1'b1, '0));

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed[n]) begin
      if (directed[n].is_cfg) begin
        drain();
        write_reg(directed[n].idx, directed[n].data);
      end else begin
        send_particle(directed[n].x, directed[n].y, directed[n].z, directed[n].last,
                      directed[n].fixed, directed[n].sum);
      end
    end

    // Random phases: small grids keep each item short, the settings vary per phase.
    for (int ph = 0; ph < 10; ph++) begin
      drain();
      quiet = (ph >= 8);
      if (ph == 3) v = 34'd1;
      else if ($urandom_range(0, 7) == 0) v = 34'($urandom_range(5, 6));
      else v = 34'($urandom_range(1, 4));
      write_reg(gcds_pkg::RegGridSize, v);
      case ($urandom_range(0, 3))
        0: v = 34'($urandom_range(1, 65535));
        1: v = 34'd65535;
        2: v = 34'd1;
        default: v = 34'd65536 / grid_cells;
      endcase
      write_reg(gcds_pkg::RegCellPitch, v);
      case ($urandom_range(0, 3))
        0: v = '0;
        1: v = CutMax;
        2: v = {2'($urandom_range(0, 3)), $urandom};
        default: v = {2'($urandom_range(0, 3)), $urandom} >> $urandom_range(0, 12);
      endcase
      write_reg(gcds_pkg::RegCutoffSq, v);
      if (ph == 3) hold_req = 1'b1;
      for (int k = 0; k < 14; k++)
        send_particle(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                      16'($urandom_range(0, 65535)), $urandom_range(0, 7) == 0, 1'b0, '0);
    end

    @(negedge clk_i);
    in_valid_i <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (50) @(posedge clk_i);
    $display("Ran %0d particles through %0d register writes, %0d results checked.",
             items_sent, cfg_writes, results_seen);
    $display("Settings covered empty, single, clamped and small grids, extreme pitches, cutoffs.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
rtl/gcds_pkg.sv
rtl/gcds_isqrt.sv
rtl/gcds_datapath.sv
rtl/gcds_ctrl.sv
rtl/grid_cutoff_distance_sum_unit.sv
rtl/gcds_checker.sv
sim/tb_top.sv
